// ===== hw/rtl/dras_pkg.sv =====
// Shared types and constants for the delayed reuse slot allocator.
package dras_pkg;

	localparam int SLOT_W  = 10;
	localparam int COUNT_W = 11;
	localparam int TIME_W  = 32;
	localparam int DELAY_W = 16;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] REG_RESERVED = 2'd0;
	localparam logic [1:0] REG_DELAY    = 2'd1;
	localparam logic [1:0] REG_GRACE    = 2'd2;

	localparam logic [SLOT_W-1:0]  RESERVED_RST = 10'd1;
	localparam logic [DELAY_W-1:0] DELAY_RST    = 16'd500;
	localparam logic [DELAY_W-1:0] GRACE_RST    = 16'd2000;

	typedef enum logic [1:0] {
		STAT_REUSED   = 2'd0,
		STAT_APPENDED = 2'd1,
		STAT_FREED    = 2'd2,
		STAT_ERROR    = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic              free;
		logic [TIME_W-1:0] stamp;
	} slot_ent_t;

endpackage

// ===== hw/rtl/dras_slot_table.sv =====
// Slot table memory: one write port, one registered read port.
module dras_slot_table #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  dras_pkg::slot_ent_t wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output dras_pkg::slot_ent_t rd_data
);
	import dras_pkg::*;

	slot_ent_t slots_q [DEPTH];
	slot_ent_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= slots_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== hw/rtl/delayed_reuse_slot_allocator.sv =====
// Top level of the delayed reuse slot allocator.
//
// Usage: raise start with operation, slot_index and now_ticks; the request is
// taken at the clock edge where start is high and busy is low. Each request
// yields one result: done is high for exactly one cycle with granted_slot,
// status and slots_in_use_count. The receiver cannot stall; results must be
// taken in the cycle they appear.
// A free request is handled in the accept cycle; its result shows in the next
// cycle and busy stays low, so frees can be issued every cycle.
// An allocate request walks the slot table from the reserved base up to the
// high-water count through the single read port of the table memory, one slot
// per cycle. busy stays high after acceptance until the first reusable slot
// has been read, or until all slots in range have been read when none
// qualifies; the result appears in the first cycle with busy low again.
// Configuration registers sit on the APB port at byte addresses 0, 4 and 8;
// they are to be written only while idle; the block does not enforce this.
// Reset clears the high-water count and loads the register defaults; the
// slot table itself is not cleared and needs no sweep.
module delayed_reuse_slot_allocator #(
	parameter int SLOT_COUNT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dras_pkg::ADDR_W-1:0]   paddr,
	input  logic [dras_pkg::DATA_W-1:0]   pwdata,
	output logic [dras_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [dras_pkg::SLOT_W-1:0]   slot_index,
	input  logic [dras_pkg::TIME_W-1:0]   now_ticks,
	output logic                          done,
	output logic [dras_pkg::SLOT_W-1:0]   granted_slot,
	output logic [1:0]                    status,
	output logic [dras_pkg::COUNT_W-1:0]  slots_in_use_count
);
	import dras_pkg::*;

	localparam int AW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int IW = (CW > SLOT_W) ? CW : SLOT_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(SLOT_COUNT);
	localparam logic [IW-1:0] SLOTS_I  = IW'(SLOT_COUNT);

	state_t state_q, state_nxt;

	logic [SLOT_W-1:0]  reserved_q;
	logic [DELAY_W-1:0] delay_q;
	logic [DELAY_W-1:0] grace_q;

	logic [CW-1:0]     hw_q, hw_nxt;
	logic [CW-1:0]     scan_q;
	logic [TIME_W-1:0] thr_q;
	logic              late_q;
	logic              rd_valid_s1;
	logic [AW-1:0]     rd_idx_s1;

	logic              done_q;
	logic [SLOT_W-1:0] slot_q;
	status_t           status_q;
	logic [COUNT_W-1:0] count_q;

	logic      cfg_wr;
	logic      accept;
	logic [IW-1:0] res_ext;
	logic [CW-1:0] base_c;
	logic [CW-1:0] hw_lift_c;
	logic      free_ok_c;
	logic      hit_c;
	logic      scan_end_c;

	logic      wr_en;
	logic [AW-1:0] wr_addr;
	slot_ent_t wr_data;
	logic      rd_en;
	slot_ent_t rd_data;

	logic      fire_c;
	logic [SLOT_W-1:0] res_slot_c;
	status_t   res_status_c;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[ADDR_W-1:2])
			REG_RESERVED: prdata = DATA_W'(reserved_q);
			REG_DELAY:    prdata = DATA_W'(delay_q);
			REG_GRACE:    prdata = DATA_W'(grace_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= RESERVED_RST;
			delay_q    <= DELAY_RST;
			grace_q    <= GRACE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[ADDR_W-1:2])
				REG_RESERVED: reserved_q <= pwdata[SLOT_W-1:0];
				REG_DELAY:    delay_q    <= pwdata[DELAY_W-1:0];
				REG_GRACE:    grace_q    <= pwdata[DELAY_W-1:0];
				default:      ;
			endcase
		end
	end

	// Request decode
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign res_ext   = IW'(reserved_q);
	assign base_c    = CW'((res_ext > SLOTS_I) ? SLOTS_I : res_ext);
	assign hw_lift_c = (hw_q < base_c) ? base_c : hw_q;
	assign free_ok_c = IW'(slot_index) < IW'(hw_q);

	// Reuse check on the slot read last cycle; thr_q holds now - delay.
	assign hit_c = rd_valid_s1 && rd_data.free &&
		((rd_data.stamp < TIME_W'(grace_q)) || (late_q && (rd_data.stamp < thr_q)));
	assign scan_end_c = !hit_c && (scan_q >= hw_q);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && operation == OP_ALLOC) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit_c || scan_end_c) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Memory access and result selection
	always_comb begin
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = '0;
		rd_en        = 1'b0;
		fire_c       = 1'b0;
		res_slot_c   = '0;
		res_status_c = STAT_ERROR;
		hw_nxt       = hw_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && operation == OP_FREE) begin
					fire_c     = 1'b1;
					res_slot_c = slot_index;
					if (free_ok_c) begin
						res_status_c  = STAT_FREED;
						wr_en         = 1'b1;
						wr_addr       = AW'(slot_index);
						wr_data.free  = 1'b1;
						wr_data.stamp = now_ticks;
					end
				end else if (accept) begin
					hw_nxt = hw_lift_c;
				end
			end
			ST_SCAN: begin
				rd_en = !hit_c && (scan_q < hw_q);
				if (hit_c) begin
					// Take the slot: clear its free flag, keep the stamp
					fire_c        = 1'b1;
					res_slot_c    = SLOT_W'(rd_idx_s1);
					res_status_c  = STAT_REUSED;
					wr_en         = 1'b1;
					wr_addr       = rd_idx_s1;
					wr_data.free  = 1'b0;
					wr_data.stamp = rd_data.stamp;
				end else if (scan_end_c) begin
					fire_c = 1'b1;
					if (hw_q != FULL_CNT) begin
						res_slot_c   = SLOT_W'(hw_q);
						res_status_c = STAT_APPENDED;
						wr_en        = 1'b1;
						wr_addr      = hw_q[AW-1:0];
						hw_nxt       = hw_q + CW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	dras_slot_table #(
		.DEPTH (SLOT_COUNT),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hw_q        <= '0;
			scan_q      <= '0;
			rd_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			hw_q        <= hw_nxt;
			rd_valid_s1 <= rd_en;
			done_q      <= fire_c;
			if (state_q == ST_IDLE) begin
				scan_q <= base_c;
			end else if (rd_en) begin
				scan_q <= scan_q + CW'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			late_q <= now_ticks > TIME_W'(delay_q);
			thr_q  <= now_ticks - TIME_W'(delay_q);
		end
		if (rd_en) begin
			rd_idx_s1 <= scan_q[AW-1:0];
		end
		if (fire_c) begin
			slot_q   <= res_slot_c;
			status_q <= res_status_c;
			count_q  <= COUNT_W'(hw_nxt);
		end
	end

	assign done               = done_q;
	assign granted_slot       = slot_q;
	assign status             = status_q;
	assign slots_in_use_count = count_q;

`ifndef NO_ASSERTIONS
	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= FULL_CNT)
		else $error("high-water count above table size");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_q <= hw_q))
		else $error("scan pointer past high-water count");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_ALLOC) |=> busy)
		else $error("allocate request did not start a scan");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_SCAN || (start && !busy && operation == OP_FREE)))
		else $error("result without a request");
`endif

endmodule

// ===== verif/slot_grant_checker.sv =====
// Checker for the slot allocator: tracks slot state, predicts each grant and compares results.
`timescale 1ns / 1ps

module slot_grant_checker #(
	parameter int SLOT_COUNT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dras_pkg::ADDR_W-1:0]   paddr,
	input  logic [dras_pkg::DATA_W-1:0]   pwdata,
	input  logic                          pready,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          operation,
	input  logic [dras_pkg::SLOT_W-1:0]   slot_index,
	input  logic [dras_pkg::TIME_W-1:0]   now_ticks,
	input  logic                          done,
	input  logic [dras_pkg::SLOT_W-1:0]   granted_slot,
	input  logic [1:0]                    status,
	input  logic [dras_pkg::COUNT_W-1:0]  slots_in_use_count,
	output int                            grant_errors,
	output int                            grants_pending,
	output int                            model_high_water
);
	import dras_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		status_t            st;
		logic [COUNT_W-1:0] cnt;
	} grant_t;

	grant_t grants_due[$];

	bit                slot_free  [SLOT_COUNT];
	logic [TIME_W-1:0] slot_stamp [SLOT_COUNT];
	int                table_hw = 0;

	logic [SLOT_W-1:0]  cfg_reserved = RESERVED_RST;
	logic [DELAY_W-1:0] cfg_delay    = DELAY_RST;
	logic [DELAY_W-1:0] cfg_grace    = GRACE_RST;

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
		grant_errors++;
	endtask

	function automatic bit slot_reusable(input int s, input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] stamp;
		if (!slot_free[s])
			return 1'b0;
		stamp = slot_stamp[s];
		if (stamp < {16'd0, cfg_grace})
			return 1'b1;
		// a now value behind the stamp means no wait has elapsed
		return (now >= stamp) && ((now - stamp) > {16'd0, cfg_delay});
	endfunction

	function automatic void push_grant(input int slot, input status_t st);
		grant_t g;
		g.slot = slot[SLOT_W-1:0];
		g.st   = st;
		g.cnt  = table_hw[COUNT_W-1:0];
		grants_due.push_back(g);
	endfunction

	task automatic predict_grant(input logic op, input logic [SLOT_W-1:0] idx,
			input logic [TIME_W-1:0] now);
		int base;
		int s;
		bit found;
		found = 1'b0;
		if (op == OP_FREE) begin
			if (int'(idx) >= table_hw) begin
				push_grant(int'(idx), STAT_ERROR);
			end else begin
				slot_free[idx]  = 1'b1;
				slot_stamp[idx] = now;
				push_grant(int'(idx), STAT_FREED);
			end
		end else begin
			base = (int'(cfg_reserved) > SLOT_COUNT) ? SLOT_COUNT : int'(cfg_reserved);
			// lift the count to the reserved base first
			if (table_hw < base)
				table_hw = base;
			for (s = base; s < table_hw && !found; s++) begin
				if (slot_reusable(s, now)) begin
					slot_free[s] = 1'b0;
					push_grant(s, STAT_REUSED);
					found = 1'b1;
				end
			end
			if (!found) begin
				if (table_hw >= SLOT_COUNT) begin
					push_grant(0, STAT_ERROR);
				end else begin
					slot_free[table_hw] = 1'b0;
					table_hw++;
					push_grant(table_hw - 1, STAT_APPENDED);
				end
			end
		end
	endtask

	task automatic check_grant();
		grant_t want;
		if (grants_due.size() == 0) begin
			report_mismatch("result with no request pending, slot", 0, granted_slot);
			return;
		end
		want = grants_due.pop_front();
		if (granted_slot !== want.slot)
			report_mismatch("granted_slot", want.slot, granted_slot);
		if (status !== want.st)
			report_mismatch("status", want.st, status);
		if (slots_in_use_count !== want.cnt)
			report_mismatch("slots_in_use_count", want.cnt, slots_in_use_count);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grants_due.delete();
			grant_errors = 0;
			table_hw     = 0;
			cfg_reserved = RESERVED_RST;
			cfg_delay    = DELAY_RST;
			cfg_grace    = GRACE_RST;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_RESERVED: cfg_reserved = pwdata[SLOT_W-1:0];
					REG_DELAY:    cfg_delay    = pwdata[DELAY_W-1:0];
					REG_GRACE:    cfg_grace    = pwdata[DELAY_W-1:0];
					default: ;
				endcase
			end
			// results belong to earlier requests, so compare before predicting
			if (done)
				check_grant();
			if (start && !busy)
				predict_grant(operation, slot_index, now_ticks);
		end
		grants_pending   = grants_due.size();
		model_high_water = table_hw;
	end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the slot allocator: clock, reset, requests, register writes and verdict.
`timescale 1ns / 1ps

module tb_top;
	import dras_pkg::*;

	localparam int SLOT_COUNT = 1024;
	localparam int STALL_LIMIT = 6000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                start = 1'b0;
	logic                busy;
	logic                operation = OP_ALLOC;
	logic [SLOT_W-1:0]   slot_index = '0;
	logic [TIME_W-1:0]   now_ticks = '0;
	logic                done;
	logic [SLOT_W-1:0]   granted_slot;
	logic [1:0]          status;
	logic [COUNT_W-1:0]  slots_in_use_count;

	int grant_errors;
	int grants_pending;
	int model_high_water;

	logic [TIME_W-1:0] clock_ms = '0;
	int tick_step = 170;
	int cur_base = 1;
	int max_base = 1;
	int burst_left = 0;
	int n_alloc = 0;
	int n_free = 0;
	int n_writes = 0;
	int n_settings = 1;
	int stall_cycles = 0;

	always #5 clk = ~clk;

	delayed_reuse_slot_allocator #(.SLOT_COUNT(SLOT_COUNT)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.operation(operation), .slot_index(slot_index), .now_ticks(now_ticks),
		.done(done), .granted_slot(granted_slot), .status(status),
		.slots_in_use_count(slots_in_use_count)
	);

	slot_grant_checker #(.SLOT_COUNT(SLOT_COUNT)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.start(start), .busy(busy),
		.operation(operation), .slot_index(slot_index), .now_ticks(now_ticks),
		.done(done), .granted_slot(granted_slot), .status(status),
		.slots_in_use_count(slots_in_use_count),
		.grant_errors(grant_errors), .grants_pending(grants_pending),
		.model_high_water(model_high_water)
	);

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pwrite && pready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_request(input logic op, input logic [SLOT_W-1:0] idx,
			input logic [TIME_W-1:0] now);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		start      <= 1'b1;
		operation  <= op;
		slot_index <= idx;
		now_ticks  <= now;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		if (op == OP_FREE)
			n_free++;
		else
			n_alloc++;
	endtask

	// hold off until every pending request has produced its result
	task automatic wait_idle();
		start <= 1'b0;
		while (grants_pending != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] regi, input logic [DATA_W-1:0] value);
		wait_idle();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {regi, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		n_writes++;
	endtask

	// before lowering the base, stamp every slot a scan could newly reach
	task automatic set_base(input int value);
		int s;
		if (value < max_base) begin
			for (s = value; s < max_base && s < model_high_water; s++)
				send_request(OP_FREE, s[SLOT_W-1:0], clock_ms);
		end
		write_reg(REG_RESERVED, value);
		if (value > max_base)
			max_base = value;
		cur_base = value;
	endtask

	task automatic apply_setting(input int base, input int delay, input int grace);
		set_base(base);
		write_reg(REG_DELAY, delay);
		write_reg(REG_GRACE, grace);
		tick_step = delay / 3 + 4;
		if ($urandom_range(0, 1) == 0)
			clock_ms = $urandom_range(0, grace);
		n_settings++;
	endtask

	task automatic run_random(input int count);
		int hw;
		int pick;
		logic [SLOT_W-1:0] idx;
		repeat (count) begin
			hw = model_high_water;
			pick = $urandom_range(0, 99);
			if (pick < 80)
				clock_ms += $urandom_range(0, tick_step);
			else if (pick < 95)
				clock_ms += $urandom_range(0, 3 * tick_step);
			else if (pick < 98)
				clock_ms -= $urandom_range(0, tick_step);
			else
				clock_ms = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				send_request(OP_ALLOC, SLOT_W'($urandom_range(0, SLOT_COUNT - 1)),
					clock_ms);
			end else if (pick < 85 && hw > cur_base) begin
				idx = SLOT_W'($urandom_range(cur_base, hw - 1));
				send_request(OP_FREE, idx, clock_ms);
			end else if (pick < 90 && hw > 0) begin
				idx = SLOT_W'($urandom_range(0, hw - 1));
				send_request(OP_FREE, idx, clock_ms);
			end else begin
				if (hw < SLOT_COUNT)
					idx = SLOT_W'($urandom_range(hw, SLOT_COUNT - 1));
				else
					idx = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
				send_request(OP_FREE, idx, clock_ms);
			end
			if ($urandom_range(0, 59) == 0)
				wait_idle();
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed requests at the reset register values
		send_request(OP_FREE,  10'd0,    32'd0);
		send_request(OP_ALLOC, 10'd1023, 32'd0);
		send_request(OP_ALLOC, 10'd0,    32'd1);
		send_request(OP_ALLOC, 10'd0,    32'd2);
		send_request(OP_FREE,  10'd2,    32'd10);
		send_request(OP_ALLOC, 10'd0,    32'd11);
		send_request(OP_FREE,  10'd1023, 32'd15);
		send_request(OP_FREE,  10'd0,    32'd20);
		send_request(OP_FREE,  10'd3,    32'd5000);
		send_request(OP_ALLOC, 10'd0,    32'd5100);
		send_request(OP_ALLOC, 10'd0,    32'd5501);
		send_request(OP_FREE,  10'd3,    32'd6000);
		send_request(OP_ALLOC, 10'd0,    32'd6500);
		send_request(OP_ALLOC, 10'd0,    32'd6501);
		send_request(OP_FREE,  10'd4,    32'd9000);
		send_request(OP_ALLOC, 10'd0,    32'd100);
		send_request(OP_FREE,  10'd1,    32'd1999);
		send_request(OP_ALLOC, 10'd0,    32'd2000);
		send_request(OP_FREE,  10'd5,    32'd2000);
		send_request(OP_ALLOC, 10'd0,    32'd2001);
		send_request(OP_ALLOC, 10'd682,  32'hFFFF_FFFF);
		send_request(OP_ALLOC, 10'd341,  32'hFFFF_FFFF);
		clock_ms = '0;

		run_random(80);
		apply_setting(0, 0, 0);
		run_random(75);
		apply_setting(6, 65535, 65535);
		run_random(75);
		apply_setting(2, 37, 0);
		run_random(75);
		apply_setting(12, 0, 65535);
		run_random(75);
		apply_setting(1, $urandom_range(0, 2000), $urandom_range(0, 65535));
		run_random(75);
		apply_setting(3, 65535, 0);
		run_random(70);

		// top base: the count reaches SLOT_COUNT and the table runs full
		apply_setting(1023, $urandom_range(0, 1000), $urandom_range(0, 3000));
		clock_ms += 10;
		send_request(OP_ALLOC, 10'd0, clock_ms);
		send_request(OP_ALLOC, 10'd0, clock_ms);
		send_request(OP_ALLOC, 10'd0, clock_ms);
		send_request(OP_FREE,  10'd1023, clock_ms);
		send_request(OP_ALLOC, 10'd0, clock_ms + 1);
		send_request(OP_FREE,  10'd7, clock_ms + 2);
		run_random(20);

		wait_idle();
		repeat (16) @(posedge clk);
		$display("Covered %0d allocate and %0d free requests over %0d register settings (%0d writes)",
			n_alloc, n_free, n_settings, n_writes);
		$display("Included grace and delay boundaries, clock rollback, base lift and lowering, full table");
		if (grants_pending != 0)
			$display("%0d expected results never arrived", grants_pending);
		if (grant_errors == 0 && grants_pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/dras_pkg.sv
hw/rtl/dras_slot_table.sv
hw/rtl/delayed_reuse_slot_allocator.sv
verif/slot_grant_checker.sv
verif/tb_top.sv
